>>> hdl/tspa_pkg.sv
// Shared constants and control bundles for the timed slot pool allocator.
package tspa_pkg;

  localparam int NUM_SLOTS_DEF = 64;

  localparam int LIFE_IN_W = 15;
  localparam int LIFE_W    = 16;
  localparam int IDX_OUT_W = 6;
  localparam int CNT_OUT_W = 7;

  localparam logic signed [LIFE_W-1:0] LIFE_MIN = 16'sh8000;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef struct packed {
    logic pop_rd;
    logic pop_commit;
    logic push;
  } free_ctl_t;

  typedef struct packed {
    logic pop_rd;
    logic push;
  } rel_ctl_t;

  typedef struct packed {
    logic alloc_we;
    logic walk_rd;
    logic walk_proc;
  } slot_ctl_t;

endpackage

>>> hdl/tspa_free_stack.sv
// Free slot stack: memory, top pointer and low-water mark for never-written entries.
module tspa_free_stack #(
  parameter int NUM_SLOTS = tspa_pkg::NUM_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tspa_pkg::free_ctl_t            ctl,
  input  logic [$clog2(NUM_SLOTS)-1:0]   push_idx,
  output logic [$clog2(NUM_SLOTS+1)-1:0] top,
  output logic [$clog2(NUM_SLOTS+1)-1:0] lwm,
  output logic [$clog2(NUM_SLOTS)-1:0]   pop_idx
);
  import tspa_pkg::*;

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(NUM_SLOTS);

  logic [IDX_W-1:0] mem [NUM_SLOTS];
  logic [IDX_W-1:0] rdata_r;
  logic [CNT_W-1:0] pos_r;
  logic             orig_r;
  logic [CNT_W-1:0] top_r, top_nxt;
  logic [CNT_W-1:0] lwm_r, lwm_nxt;
  logic [CNT_W-1:0] pop_pos;
  logic             push_ok;

  // entries below the lowest top ever reached were never written; a pop there returns its own position
  assign pop_pos = top_r - CNT_W'(1);
  assign push_ok = ctl.push && (top_r < FULL);

  always_ff @(posedge clk) begin
    if (ctl.pop_rd) begin
      rdata_r <= mem[pop_pos[IDX_W-1:0]];
      pos_r   <= pop_pos;
      orig_r  <= (pop_pos < lwm_r);
    end
    if (push_ok) begin
      mem[top_r[IDX_W-1:0]] <= push_idx;
    end
  end

  always_comb begin
    top_nxt = top_r;
    lwm_nxt = lwm_r;
    if (ctl.pop_commit) begin
      top_nxt = top_r - CNT_W'(1);
      if (orig_r) begin
        lwm_nxt = pos_r;
      end
    end else if (push_ok) begin
      top_nxt = top_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= FULL;
      lwm_r <= FULL;
    end else begin
      top_r <= top_nxt;
      lwm_r <= lwm_nxt;
    end
  end

  assign top     = top_r;
  assign lwm     = lwm_r;
  assign pop_idx = orig_r ? pos_r[IDX_W-1:0] : rdata_r;

endmodule

>>> hdl/tspa_release_stack.sv
// Pending-release stack: memory and top pointer.
module tspa_release_stack #(
  parameter int NUM_SLOTS = tspa_pkg::NUM_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tspa_pkg::rel_ctl_t             ctl,
  input  logic [$clog2(NUM_SLOTS)-1:0]   push_idx,
  output logic [$clog2(NUM_SLOTS+1)-1:0] top,
  output logic [$clog2(NUM_SLOTS)-1:0]   rdata
);
  import tspa_pkg::*;

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(NUM_SLOTS);

  logic [IDX_W-1:0] mem [NUM_SLOTS];
  logic [IDX_W-1:0] rdata_r;
  logic [CNT_W-1:0] top_r, top_nxt;
  logic [CNT_W-1:0] pop_pos;
  logic             push_ok;

  assign pop_pos = top_r - CNT_W'(1);
  assign push_ok = ctl.push && (top_r < FULL);

  always_ff @(posedge clk) begin
    if (ctl.pop_rd) begin
      rdata_r <= mem[pop_pos[IDX_W-1:0]];
    end
    if (push_ok) begin
      mem[top_r[IDX_W-1:0]] <= push_idx;
    end
  end

  always_comb begin
    top_nxt = top_r;
    if (ctl.pop_rd) begin
      top_nxt = pop_pos;
    end else if (push_ok) begin
      top_nxt = top_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;
    end else begin
      top_r <= top_nxt;
    end
  end

  assign top   = top_r;
  assign rdata = rdata_r;

endmodule

>>> hdl/tspa_slot_table.sv
// Slot table: active flag and lifetime per slot, load on allocate, age on tick walk.
module tspa_slot_table #(
  parameter int NUM_SLOTS = tspa_pkg::NUM_SLOTS_DEF
) (
  input  logic                              clk,
  input  tspa_pkg::slot_ctl_t               ctl,
  input  logic [$clog2(NUM_SLOTS)-1:0]      alloc_idx,
  input  logic [tspa_pkg::LIFE_IN_W-1:0]    alloc_life,
  input  logic [$clog2(NUM_SLOTS)-1:0]      walk_addr,
  input  logic [$clog2(NUM_SLOTS+1)-1:0]    lwm,
  output logic                              expire,
  output logic [$clog2(NUM_SLOTS)-1:0]      proc_idx
);
  import tspa_pkg::*;

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  typedef struct packed {
    logic                     act;
    logic signed [LIFE_W-1:0] life;
  } slot_ent_t;

  slot_ent_t        mem [NUM_SLOTS];
  slot_ent_t        rd_r;
  logic [IDX_W-1:0] idx_r;
  slot_ent_t        wd;
  logic [IDX_W-1:0] wa;
  logic             we;
  logic             act;

  // slots below the free-stack low-water mark were never allocated
  assign act    = rd_r.act && (CNT_W'(idx_r) >= lwm);
  assign expire = ctl.walk_proc && act && rd_r.life[LIFE_W-1];

  always_comb begin
    we = 1'b0;
    wa = alloc_idx;
    wd.act  = 1'b1;
    wd.life = LIFE_W'({1'b0, alloc_life});
    if (ctl.alloc_we) begin
      we = 1'b1;
    end else if (ctl.walk_proc && act) begin
      we      = 1'b1;
      wa      = idx_r;
      wd.act  = ~rd_r.life[LIFE_W-1];
      wd.life = (rd_r.life == LIFE_MIN) ? rd_r.life : rd_r.life - 16'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.walk_rd) begin
      rd_r  <= mem[walk_addr];
      idx_r <= walk_addr;
    end
    if (we) begin
      mem[wa] <= wd;
    end
  end

  assign proc_idx = idx_r;

endmodule

>>> hdl/timed_slot_pool_allocator_top.sv
// Top level of the timed slot pool allocator: command sequencer and result register.
//
//  channel  | ports                                   | transfer
//  ---------+-----------------------------------------+------------------------------
//  input    | in_req_type, in_lifetime_frames         | start high while busy low
//  result   | out_granted, out_slot_index,            | out_strobe high, one cycle,
//           | out_expired_count, out_free_count       | no backpressure
//
//  Allocate: free-stack read in the transfer cycle, then slot-table write in ST_ALLOC;
//  the result is registered from ST_ALLOC; the next command may transfer as it strobes.
//  Tick: release-stack drain of the slots pending release, then slot-table walk over
//  all NUM_SLOTS entries, one entry per cycle; the result strobes after the walk.
//  Reset: synchronous, rst_n low; no clearing pass, the block is ready right after.
//  The receiver cannot stall; results are never held back.
module timed_slot_pool_allocator_top #(
  parameter int NUM_SLOTS = tspa_pkg::NUM_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_req_type,
  input  logic [tspa_pkg::LIFE_IN_W-1:0]   in_lifetime_frames,
  output logic                             out_strobe,
  output logic                             out_granted,
  output logic [tspa_pkg::IDX_OUT_W-1:0]   out_slot_index,
  output logic [tspa_pkg::CNT_OUT_W-1:0]   out_expired_count,
  output logic [tspa_pkg::CNT_OUT_W-1:0]   out_free_count
);
  import tspa_pkg::*;

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(NUM_SLOTS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_WALK  = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic                 hit_r, hit_nxt;
  logic [LIFE_IN_W-1:0] life_r, life_nxt;
  logic [CNT_W-1:0]     walk_addr_r, walk_addr_nxt;
  logic                 walk_v_r, walk_v_nxt;
  logic                 drain_v_r, drain_v_nxt;
  logic [CNT_W-1:0]     expired_r, expired_nxt;

  logic                 out_strobe_r, out_strobe_nxt;
  logic                 out_granted_r, out_granted_nxt;
  logic [IDX_OUT_W-1:0] out_slot_index_r, out_slot_index_nxt;
  logic [CNT_OUT_W-1:0] out_expired_count_r, out_expired_count_nxt;
  logic [CNT_OUT_W-1:0] out_free_count_r, out_free_count_nxt;

  free_ctl_t        free_ctl;
  rel_ctl_t         rel_ctl;
  slot_ctl_t        slot_ctl;
  logic [CNT_W-1:0] free_top, free_lwm, rel_top;
  logic [IDX_W-1:0] pop_idx, rel_rdata, proc_idx;
  logic             expire;
  logic             accept;

  assign accept = start && (state_r == ST_IDLE);

  tspa_free_stack #(.NUM_SLOTS(NUM_SLOTS)) u_free (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (free_ctl),
    .push_idx (rel_rdata),
    .top      (free_top),
    .lwm      (free_lwm),
    .pop_idx  (pop_idx)
  );

  tspa_release_stack #(.NUM_SLOTS(NUM_SLOTS)) u_rel (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (rel_ctl),
    .push_idx (proc_idx),
    .top      (rel_top),
    .rdata    (rel_rdata)
  );

  tspa_slot_table #(.NUM_SLOTS(NUM_SLOTS)) u_slots (
    .clk        (clk),
    .ctl        (slot_ctl),
    .alloc_idx  (pop_idx),
    .alloc_life (life_r),
    .walk_addr  (walk_addr_r[IDX_W-1:0]),
    .lwm        (free_lwm),
    .expire     (expire),
    .proc_idx   (proc_idx)
  );

  always_comb begin
    state_nxt     = state_r;
    hit_nxt       = hit_r;
    life_nxt      = life_r;
    walk_addr_nxt = walk_addr_r;
    walk_v_nxt    = 1'b0;
    drain_v_nxt   = 1'b0;
    expired_nxt   = expired_r + CNT_W'(expire);

    out_strobe_nxt        = 1'b0;
    out_granted_nxt       = 1'b0;
    out_slot_index_nxt    = '0;
    out_expired_count_nxt = '0;
    out_free_count_nxt    = '0;

    free_ctl.pop_rd     = 1'b0;
    free_ctl.pop_commit = 1'b0;
    free_ctl.push       = drain_v_r;
    rel_ctl.pop_rd      = 1'b0;
    rel_ctl.push        = expire;
    slot_ctl.alloc_we   = 1'b0;
    slot_ctl.walk_rd    = 1'b0;
    slot_ctl.walk_proc  = walk_v_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_type == REQ_ALLOC) begin
            hit_nxt         = (free_top != '0);
            free_ctl.pop_rd = (free_top != '0);
            life_nxt        = in_lifetime_frames;
            state_nxt       = ST_ALLOC;
          end else begin
            walk_addr_nxt = '0;
            expired_nxt   = '0;
            state_nxt     = ST_DRAIN;
          end
        end
      end
      ST_ALLOC: begin
        free_ctl.pop_commit = hit_r;
        slot_ctl.alloc_we   = hit_r;
        out_strobe_nxt      = 1'b1;
        out_granted_nxt     = hit_r;
        out_slot_index_nxt  = hit_r ? IDX_OUT_W'(pop_idx) : '0;
        out_free_count_nxt  = CNT_OUT_W'(hit_r ? free_top - CNT_W'(1) : free_top);
        state_nxt           = ST_IDLE;
      end
      ST_DRAIN: begin
        if (rel_top != '0) begin
          rel_ctl.pop_rd = 1'b1;
          drain_v_nxt    = 1'b1;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_addr_r != FULL) begin
          slot_ctl.walk_rd = 1'b1;
          walk_v_nxt       = 1'b1;
          walk_addr_nxt    = walk_addr_r + CNT_W'(1);
        end else begin
          out_strobe_nxt        = 1'b1;
          out_expired_count_nxt = CNT_OUT_W'(expired_nxt);
          out_free_count_nxt    = CNT_OUT_W'(free_top);
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      walk_v_r     <= 1'b0;
      drain_v_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      walk_v_r     <= walk_v_nxt;
      drain_v_r    <= drain_v_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r               <= hit_nxt;
    life_r              <= life_nxt;
    walk_addr_r         <= walk_addr_nxt;
    expired_r           <= expired_nxt;
    out_granted_r       <= out_granted_nxt;
    out_slot_index_r    <= out_slot_index_nxt;
    out_expired_count_r <= out_expired_count_nxt;
    out_free_count_r    <= out_free_count_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_strobe        = out_strobe_r;
  assign out_granted       = out_granted_r;
  assign out_slot_index    = out_slot_index_r;
  assign out_expired_count = out_expired_count_r;
  assign out_free_count    = out_free_count_r;

endmodule

>>> hdl/tspa_checker.sv
// Port-level checker for the timed slot pool allocator, bound to the top level.
module tspa_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             in_req_type,
  input logic                             out_strobe,
  input logic                             out_granted,
  input logic [tspa_pkg::IDX_OUT_W-1:0]   out_slot_index,
  input logic [tspa_pkg::CNT_OUT_W-1:0]   out_expired_count
);
  import tspa_pkg::*;

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after input transfer");

  a_alloc_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_req_type == REQ_ALLOC) |=> ##1 out_strobe)
    else $error("allocate result not on time");

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without work in progress");

  a_no_grant_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_granted |-> (out_slot_index == '0))
    else $error("nonzero slot index without grant");

  a_grant_no_expiry: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_granted |-> (out_expired_count == '0))
    else $error("expired count on an allocate result");

endmodule

bind timed_slot_pool_allocator_top tspa_checker u_tspa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_req_type       (in_req_type),
  .out_strobe        (out_strobe),
  .out_granted       (out_granted),
  .out_slot_index    (out_slot_index),
  .out_expired_count (out_expired_count)
);
